// ===== rtl/rcadc_pkg.sv =====
// ----------------------------------------------------------------------------
// rcadc_pkg
// Shared widths, codes and thresholds for the stick and button ladder decoder.
// ----------------------------------------------------------------------------
package rcadc_pkg;

  // Field widths
  localparam int unsigned ChanW   = 3;
  localparam int unsigned SampleW = 12;
  localparam int unsigned KeysN   = 8;
  localparam int unsigned SlotW   = 3;
  localparam int unsigned PulseW  = 11;
  localparam int unsigned CntW    = 2;
  localparam int unsigned CfgIdxW = 3;

  // Stream word widths (fields packed from bit 0, padded to whole bytes)
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 24;

  // Channel codes
  localparam logic [ChanW-1:0] CH_LADDER_LO = 3'd4;  // keys 0-3
  localparam logic [ChanW-1:0] CH_LADDER_HI = 3'd5;  // keys 4-7

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_SLOT0 = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SLOT1 = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SLOT2 = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SLOT3 = 3'd3;

  // Stick mapping
  localparam logic [SampleW-1:0] STICK_LOW   = 12'd512;
  localparam logic [SampleW-1:0] STICK_HIGH  = 12'd3586;
  localparam logic [PulseW-1:0]  PULSE_MIN   = 11'd1000;
  localparam logic [PulseW-1:0]  PULSE_MAX   = 11'd2000;
  localparam logic [19:0]        STICK_GAIN  = 20'd125;
  localparam logic [19:0]        STICK_OFFS  = 20'd320000;
  // (2^17 + 1) / 3: exact floor division by three for values below 2^16
  localparam logic [16:0]        DIV3_RECIP  = 17'd43691;

  // Ladder thresholds (all windows open on both ends)
  localparam logic [SampleW-1:0] LADDER_RELEASE = 12'd4000;
  localparam logic [SampleW-1:0] KEY0_LO = 12'd0;
  localparam logic [SampleW-1:0] KEY0_HI = 12'd9;
  localparam logic [SampleW-1:0] KEY1_LO = 12'd980;
  localparam logic [SampleW-1:0] KEY1_HI = 12'd1020;
  localparam logic [SampleW-1:0] KEY2_LO = 12'd2040;
  localparam logic [SampleW-1:0] KEY2_HI = 12'd2070;
  localparam logic [SampleW-1:0] KEY3_LO = 12'd3040;
  localparam logic [SampleW-1:0] KEY3_HI = 12'd3090;

  localparam logic [CntW-1:0] CNT_LATCH = 2'd3;

  typedef logic [CntW-1:0] press_cnt_t;

endpackage

// ===== rtl/rc_adc_stick_and_button_decoder.sv =====
// ----------------------------------------------------------------------------
// rc_adc_stick_and_button_decoder
// Maps stick ADC samples to PPM pulse widths and debounces two resistor-ladder
// button groups into latched key event bits.
// ----------------------------------------------------------------------------
//  channel   | direction | word contents
//  s_axis    | in        | tuser: channel; tdata: sample, clear_mask
//  m_axis    | out       | tuser: pulse_valid; tdata: ppm_slot, pulse_us,
//            |           |   key_events
//  cfg       | in        | cfg_index_i selects slot_of_stick0..3
//
//  One word enters per cycle while m_axis does not stall; it passes the input
//  register and is offered from the result register. Debounce state updates as a
//  word moves from the input register to the result register, so the next word
//  sees it without a bubble. A stalled m_axis holds both registers; s_axis
//  keeps accepting while the input register is free. Reset clears counters
//  and event bits and loads slots 0..3; no clearing pass is needed.
// ----------------------------------------------------------------------------
module rc_adc_stick_and_button_decoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [rcadc_pkg::InDataW-1:0]     s_axis_tdata,  // [11:0] sample, [19:12] clear_mask
  input  logic [rcadc_pkg::ChanW-1:0]       s_axis_tuser,  // [2:0] channel
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [rcadc_pkg::OutDataW-1:0]    m_axis_tdata,  // [2:0] ppm_slot, [13:3] pulse_us,
                                                           // [21:14] key_events
  output logic                              m_axis_tuser,  // [0] pulse_valid
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rcadc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [rcadc_pkg::SlotW-1:0]       cfg_data_i
);
  import rcadc_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration: stick to slot map
  // --------------------------------------------------------------------------
  logic [SlotW-1:0] slot_q [4];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q[0] <= 3'd0;
      slot_q[1] <= 3'd1;
      slot_q[2] <= 3'd2;
      slot_q[3] <= 3'd3;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SLOT0: slot_q[0] <= cfg_data_i;
        REG_SLOT1: slot_q[1] <= cfg_data_i;
        REG_SLOT2: slot_q[2] <= cfg_data_i;
        REG_SLOT3: slot_q[3] <= cfg_data_i;
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic               in_valid_q, in_valid_d;
  logic [ChanW-1:0]   chan_q;
  logic [SampleW-1:0] sample_q;
  logic [KeysN-1:0]   clr_q;
  logic [12:0]        scaled_q;   // (sample*125 + 320000) / 128
  logic [19:0]        scaled_full;
  logic               in_accept;
  logic               advance;

  assign advance       = in_valid_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Scale the sample on the way in; the divide by three follows next stage
  assign scaled_full = 20'(s_axis_tdata[SampleW-1:0]) * STICK_GAIN + STICK_OFFS;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      chan_q   <= s_axis_tuser;
      sample_q <= s_axis_tdata[SampleW-1:0];
      clr_q    <= s_axis_tdata[SampleW+KeysN-1:SampleW];
      scaled_q <= scaled_full[19:7];
    end
  end

  // --------------------------------------------------------------------------
  // Stick mapping
  // --------------------------------------------------------------------------
  logic              is_stick;
  logic [29:0]       div3_prod;
  logic [PulseW-1:0] pulse_d;
  logic [SlotW-1:0]  slot_d;

  assign is_stick  = chan_q < CH_LADDER_LO;
  assign div3_prod = 30'(scaled_q) * 30'(DIV3_RECIP);

  always_comb begin
    pulse_d = '0;
    slot_d  = '0;
    if (is_stick) begin
      slot_d = slot_q[chan_q[1:0]];
      if (sample_q <= STICK_LOW) begin
        pulse_d = PULSE_MIN;
      end else if (sample_q >= STICK_HIGH) begin
        pulse_d = PULSE_MAX;
      end else begin
        pulse_d = div3_prod[27:17];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Ladder decode and debounce
  // --------------------------------------------------------------------------
  press_cnt_t       cnt_q [KeysN];
  press_cnt_t       cnt_d [KeysN];
  logic [KeysN-1:0] latched_q, latched_d, latched_clr;
  logic             is_ladder, grp_hi, release_hit, key_hit;
  logic [1:0]       key_sel;

  assign is_ladder   = (chan_q == CH_LADDER_LO) || (chan_q == CH_LADDER_HI);
  assign grp_hi      = chan_q == CH_LADDER_HI;
  assign release_hit = sample_q > LADDER_RELEASE;
  assign latched_clr = latched_q & ~clr_q;

  // Pick the key window, checking keys 3, 2, 0, then 1
  always_comb begin
    key_hit = 1'b1;
    key_sel = 2'd0;
    if (sample_q > KEY3_LO && sample_q < KEY3_HI) begin
      key_sel = 2'd3;
    end else if (sample_q > KEY2_LO && sample_q < KEY2_HI) begin
      key_sel = 2'd2;
    end else if (sample_q > KEY0_LO && sample_q < KEY0_HI) begin
      key_sel = 2'd0;
    end else if (sample_q > KEY1_LO && sample_q < KEY1_HI) begin
      key_sel = 2'd1;
    end else begin
      key_hit = 1'b0;
    end
  end

  // Per-key counter and latch update
  always_comb begin
    latched_d = latched_clr;
    for (int k = 0; k < KeysN; k++) begin
      cnt_d[k] = cnt_q[k];
      if (is_ladder && ((k / 4 == 1) == grp_hi)) begin
        if (release_hit) begin
          cnt_d[k] = '0;
        end else if (key_hit && (2'(k % 4) == key_sel) &&
                     (cnt_q[k] != CNT_LATCH) && !latched_clr[k]) begin
          cnt_d[k] = cnt_q[k] + 2'd1;
          if (cnt_q[k] == CNT_LATCH - 2'd1) begin
            latched_d[k] = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latched_q <= '0;
      for (int k = 0; k < KeysN; k++) begin
        cnt_q[k] <= '0;
      end
    end else if (advance) begin
      latched_q <= latched_d;
      for (int k = 0; k < KeysN; k++) begin
        cnt_q[k] <= cnt_d[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic              out_valid_q, out_valid_d;
  logic              pulse_valid_q;
  logic [SlotW-1:0]  slot_out_q;
  logic [PulseW-1:0] pulse_out_q;
  logic [KeysN-1:0]  keys_out_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      pulse_valid_q <= is_stick;
      slot_out_q    <= slot_d;
      pulse_out_q   <= pulse_d;
      keys_out_q    <= latched_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = pulse_valid_q;
  assign m_axis_tdata  = {2'b00, keys_out_q, pulse_out_q, slot_out_q};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A non-stick result carries no slot or pulse width
  a_nonstick_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pulse_valid_q) |-> (slot_out_q == '0 && pulse_out_q == '0))
    else $error("non-stick result has nonzero pulse fields");

  // A stick pulse width stays within 1000..2000 us
  a_pulse_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && pulse_valid_q) |-> (pulse_out_q >= PULSE_MIN && pulse_out_q <= PULSE_MAX))
    else $error("stick pulse width out of range");

  // New event bits only come from a ladder word moving forward
  a_latch_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|(latched_d & ~latched_q) && advance) |-> is_ladder)
    else $error("event bit set by a non-ladder word");

  // Debounce state moves only when a word advances
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(advance) |-> $stable(latched_q))
    else $error("event bits changed without an advancing word");

  // A stalled result blocks the input register when it is full
  a_stall_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while pipeline is stalled and full");

endmodule
